// File: hdl/hds_pkg.sv
// shared types and constants for the heat diffusion stencil step
`timescale 1ns / 1ps

package hds_pkg;

    // default sizes
    localparam int MAX_COLS_DEF  = 1024;
    localparam int MAX_ROWS_DEF  = 1024;
    localparam int FRAC_BITS_DEF = 24;

    // field widths
    localparam int VAL_W      = 32;
    localparam int CX_W       = 24;
    localparam int SIZE_CFG_W = 11;
    localparam int IDX_OUT_W  = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // datapath widths: second difference, weighted term, sum of both terms
    localparam int DIFF_W = VAL_W + 2;
    localparam int PROD_W = CX_W + 1 + DIFF_W;
    localparam int SUM_W  = PROD_W + 1;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_BOUND  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_BOUND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd5;

    // register reset values
    localparam logic signed [VAL_W-1:0]  LEFT_BOUND_RST  = 32'sd16777216;
    localparam logic signed [VAL_W-1:0]  RIGHT_BOUND_RST = 32'sd0;
    localparam logic [SIZE_CFG_W-1:0]    GRID_SIZE_RST   = 11'd20;
    localparam logic [SIZE_CFG_W-1:0]    GRID_SIZE_MIN   = 11'd3;

    // saturation limits
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fffffff;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh80000000;
    localparam logic signed [SUM_W-1:0] SAT_HI  = SUM_W'(VAL_MAX);
    localparam logic signed [SUM_W-1:0] SAT_LO  = SUM_W'(VAL_MIN);

    // source of a result value
    typedef enum logic [1:0] {
        SEL_LEFT,
        SEL_RIGHT,
        SEL_INNER
    } hds_sel_t;

    // per-cell control carried down the pipe
    typedef struct packed {
        logic                 emit;
        hds_sel_t             sel;
        logic                 top;
        logic                 bot;
        logic                 last;
        logic [IDX_OUT_W-1:0] row;
        logic [IDX_OUT_W-1:0] col;
    } hds_meta_t;

endpackage

// File: hdl/heat_diffusion_stencil_step.sv
// top level: one explicit time step of 2-d heat diffusion on a streamed grid
`timescale 1ns / 1ps

// Streams one old grid in raster order, one cell per request, and returns the
// new grid one cell per request with its row and column. Two line memories of
// MAX_COLS words (the previous row and the row before it) plus a four-word
// window give the five-point neighborhood; each memory is read once and
// written once per cell, which sets the rate at one input cell per clock
// when the pipe is not stalled. Interior cells go through a four-stage pipe
// (memory read, differences, multiply, rounded sum) and an output register
// that adds and saturates. Rows 0 and 1 emit nothing; from row 2 on each
// cell emits the cell one row up (column 0 gives the left boundary, column 1
// the right boundary, column c the interior column c-1). Cells of row 1 also
// emit their copy for row 0 and cells of row H-2 their copy for row H-1, so
// there the output sends two copies per cell (three when the grid is 3 rows
// high) and input is held off while the extra copies go out.
// grid_done marks the last result of the grid. Configure only while idle.
module heat_diffusion_stencil_step
    import hds_pkg::*;
#(
    parameter int MAX_COLS  = MAX_COLS_DEF,
    parameter int MAX_ROWS  = MAX_ROWS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration writes
    input  logic                         cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    // old cells
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [VAL_W-1:0]      s_cell_value,
    // new cells
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [IDX_OUT_W-1:0]         m_row_index,
    output logic [IDX_OUT_W-1:0]         m_col_index,
    output logic signed [VAL_W-1:0]      m_new_value,
    output logic                         m_grid_done
);

    // counter and size widths
    localparam int CNT_W  = $clog2(MAX_COLS);
    localparam int W_W    = $clog2(MAX_COLS + 1);
    localparam int RCNT_W = $clog2(MAX_ROWS);
    localparam int H_W    = $clog2(MAX_ROWS + 1);
    localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) << (FRAC_BITS - 1);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CX_W-1:0]         coeff_x_reg;
    logic [CX_W-1:0]         coeff_y_reg;
    logic signed [VAL_W-1:0] left_bound_reg;
    logic signed [VAL_W-1:0] right_bound_reg;
    logic [SIZE_CFG_W-1:0]   grid_width_reg;
    logic [SIZE_CFG_W-1:0]   grid_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeff_x_reg     <= '0;
            coeff_y_reg     <= '0;
            left_bound_reg  <= LEFT_BOUND_RST;
            right_bound_reg <= RIGHT_BOUND_RST;
            grid_width_reg  <= GRID_SIZE_RST;
            grid_height_reg <= GRID_SIZE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_COEFF_X:     coeff_x_reg     <= cfg_data[CX_W-1:0];
                REG_COEFF_Y:     coeff_y_reg     <= cfg_data[CX_W-1:0];
                REG_LEFT_BOUND:  left_bound_reg  <= $signed(cfg_data[VAL_W-1:0]);
                REG_RIGHT_BOUND: right_bound_reg <= $signed(cfg_data[VAL_W-1:0]);
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_data[SIZE_CFG_W-1:0];
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data[SIZE_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // sizes in use, clamped to 3 .. MAX
    logic [W_W-1:0] w_lim;
    logic [H_W-1:0] h_lim;

    always_comb begin
        if (grid_width_reg < GRID_SIZE_MIN) begin
            w_lim = W_W'(3);
        end else if (32'(grid_width_reg) > 32'(MAX_COLS)) begin
            w_lim = W_W'(MAX_COLS);
        end else begin
            w_lim = W_W'(grid_width_reg);
        end
        if (grid_height_reg < GRID_SIZE_MIN) begin
            h_lim = H_W'(3);
        end else if (32'(grid_height_reg) > 32'(MAX_ROWS)) begin
            h_lim = H_W'(MAX_ROWS);
        end else begin
            h_lim = H_W'(grid_height_reg);
        end
    end

    // ------------------------------------------------------------------
    // pipe control: each stage moves when the next one is empty or moving
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, e_valid_reg;
    logic en1, en2, en3, en4;
    logic e_done;
    logic in_accept;
    logic adv1;

    assign en4       = !e_valid_reg || e_done;
    assign en3       = !v4_reg || en4;
    assign en2       = !v3_reg || en3;
    assign en1       = !v2_reg || en2;
    assign s_ready   = !v1_reg || en1;
    assign in_accept = s_valid && s_ready;
    assign adv1      = v1_reg && en1;

    // ------------------------------------------------------------------
    // raster position of the next input cell
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]  col_cnt_reg, col_cnt_next;
    logic [RCNT_W-1:0] row_cnt_reg, row_cnt_next;
    logic [W_W-1:0]    col_p1;
    logic [H_W-1:0]    row_p1;
    logic              col_wrap;
    logic              row_wrap;

    always_comb begin
        col_p1   = W_W'(col_cnt_reg) + W_W'(1);
        row_p1   = H_W'(row_cnt_reg) + H_W'(1);
        col_wrap = col_p1 >= w_lim;
        row_wrap = row_p1 >= h_lim;
        if (col_wrap) begin
            col_cnt_next = '0;
            row_cnt_next = row_wrap ? '0 : row_p1[RCNT_W-1:0];
        end else begin
            col_cnt_next = col_p1[CNT_W-1:0];
            row_cnt_next = row_cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end else if (in_accept) begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // what the arriving cell will emit (it serves the row one above)
    hds_meta_t in_meta;

    always_comb begin
        in_meta.emit = (W_W'(col_cnt_reg) < w_lim) && (H_W'(row_cnt_reg) < h_lim)
                       && (row_cnt_reg >= RCNT_W'(2));
        in_meta.top  = row_cnt_reg == RCNT_W'(2);
        in_meta.bot  = row_p1 == h_lim;
        in_meta.last = (row_p1 == h_lim) && (col_p1 == w_lim);
        in_meta.row  = IDX_OUT_W'(32'(row_cnt_reg) - 32'd1);
        priority if (col_cnt_reg == CNT_W'(0)) begin
            in_meta.sel = SEL_LEFT;
            in_meta.col = '0;
        end else if (col_cnt_reg == CNT_W'(1)) begin
            in_meta.sel = SEL_RIGHT;
            in_meta.col = IDX_OUT_W'(32'(w_lim) - 32'd1);
        end else begin
            in_meta.sel = SEL_INNER;
            in_meta.col = IDX_OUT_W'(32'(col_cnt_reg) - 32'd1);
        end
    end

    // ------------------------------------------------------------------
    // line memories: prev holds the last row, prev2 the row before it
    // ------------------------------------------------------------------
    logic signed [VAL_W-1:0] row_prev_mem  [MAX_COLS];
    logic signed [VAL_W-1:0] row_prev2_mem [MAX_COLS];
    logic signed [VAL_W-1:0] rd_prev_reg;
    logic signed [VAL_W-1:0] rd_prev2_reg;
    logic [CNT_W-1:0]        s1_addr_reg;

    // read-first: the old entry is read while the new cell replaces it
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            rd_prev_reg                <= row_prev_mem[col_cnt_reg];
            row_prev_mem[col_cnt_reg]  <= s_cell_value;
        end
    end

    // prev2 takes the old prev entry once it has been read
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            rd_prev2_reg <= row_prev2_mem[col_cnt_reg];
        end
        if (adv1) begin
            row_prev2_mem[s1_addr_reg] <= rd_prev_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: window and second differences
    // ------------------------------------------------------------------
    hds_meta_t               s1_meta_reg;
    logic signed [VAL_W-1:0] s1_cell_reg;

    // window: west-to-be, center-to-be, north, south
    logic signed [VAL_W-1:0] win_a_reg;
    logic signed [VAL_W-1:0] win_b_reg;
    logic signed [VAL_W-1:0] north_reg;
    logic signed [VAL_W-1:0] south_reg;

    logic signed [DIFF_W-1:0] dxx_next;
    logic signed [DIFF_W-1:0] dyy_next;

    always_comb begin
        dxx_next = DIFF_W'(win_a_reg) - (DIFF_W'(win_b_reg) <<< 1) + DIFF_W'(rd_prev_reg);
        dyy_next = DIFF_W'(north_reg) - (DIFF_W'(win_b_reg) <<< 1) + DIFF_W'(south_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (s_ready) begin
            v1_reg <= s_valid;
        end
        if (in_accept) begin
            s1_meta_reg <= in_meta;
            s1_cell_reg <= s_cell_value;
            s1_addr_reg <= col_cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_a_reg <= '0;
            win_b_reg <= '0;
            north_reg <= '0;
            south_reg <= '0;
        end else if (adv1) begin
            win_a_reg <= win_b_reg;
            win_b_reg <= rd_prev_reg;
            north_reg <= rd_prev2_reg;
            south_reg <= s1_cell_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: weighted terms
    // ------------------------------------------------------------------
    hds_meta_t                s2_meta_reg;
    logic signed [DIFF_W-1:0] dxx_reg;
    logic signed [DIFF_W-1:0] dyy_reg;
    logic signed [VAL_W-1:0]  s2_u_reg;
    logic signed [CX_W:0]     cx_s;
    logic signed [CX_W:0]     cy_s;
    logic signed [PROD_W-1:0] prodx_next;
    logic signed [PROD_W-1:0] prody_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en1) begin
            v2_reg <= v1_reg && s1_meta_reg.emit;  // rows 0 and 1 stop here
        end
        if (en1) begin
            s2_meta_reg <= s1_meta_reg;
            dxx_reg     <= dxx_next;
            dyy_reg     <= dyy_next;
            s2_u_reg    <= win_b_reg;
        end
    end

    always_comb begin
        cx_s       = $signed({1'b0, coeff_x_reg});
        cy_s       = $signed({1'b0, coeff_y_reg});
        prodx_next = cx_s * dxx_reg;
        prody_next = cy_s * dyy_reg;
    end

    // ------------------------------------------------------------------
    // stage 3: sum of both terms plus half an lsb for rounding
    // ------------------------------------------------------------------
    hds_meta_t                s3_meta_reg;
    logic signed [PROD_W-1:0] prodx_reg;
    logic signed [PROD_W-1:0] prody_reg;
    logic signed [VAL_W-1:0]  s3_u_reg;
    logic signed [SUM_W-1:0]  rsum_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en2) begin
            v3_reg <= v2_reg;
        end
        if (en2) begin
            s3_meta_reg <= s2_meta_reg;
            prodx_reg   <= prodx_next;
            prody_reg   <= prody_next;
            s3_u_reg    <= s2_u_reg;
        end
    end

    assign rsum_next = SUM_W'(prodx_reg) + SUM_W'(prody_reg) + RND_HALF;

    // ------------------------------------------------------------------
    // stage 4: scale, add to the center value, saturate, pick the source
    // ------------------------------------------------------------------
    hds_meta_t               s4_meta_reg;
    logic signed [SUM_W-1:0] rsum_reg;
    logic signed [VAL_W-1:0] s4_u_reg;
    logic signed [SUM_W-1:0] term_s;
    logic signed [SUM_W-1:0] total_s;
    logic signed [VAL_W-1:0] sat_val;
    logic signed [VAL_W-1:0] res_val;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en3) begin
            v4_reg <= v3_reg;
        end
        if (en3) begin
            s4_meta_reg <= s3_meta_reg;
            rsum_reg    <= rsum_next;
            s4_u_reg    <= s3_u_reg;
        end
    end

    always_comb begin
        term_s  = rsum_reg >>> FRAC_BITS;
        total_s = term_s + SUM_W'(s4_u_reg);
        if (total_s > SAT_HI) begin
            sat_val = VAL_MAX;
        end else if (total_s < SAT_LO) begin
            sat_val = VAL_MIN;
        end else begin
            sat_val = $signed(total_s[VAL_W-1:0]);
        end
        unique case (s4_meta_reg.sel)
            SEL_LEFT:  res_val = left_bound_reg;
            SEL_RIGHT: res_val = right_bound_reg;
            SEL_INNER: res_val = sat_val;
            default:   res_val = sat_val;
        endcase
    end

    // ------------------------------------------------------------------
    // output register: one cell, up to three copies (row 0, own row, last row)
    // ------------------------------------------------------------------
    hds_meta_t               e_meta_reg;
    logic signed [VAL_W-1:0] e_value_reg;
    logic [2:0]              e_pend_reg;   // bit 0 top copy, bit 1 own row, bit 2 bottom copy
    logic [2:0]              pick;
    logic [2:0]              pend_after;

    always_comb begin
        priority if (e_pend_reg[0]) begin
            pick        = 3'b001;
            m_row_index = '0;
        end else if (e_pend_reg[1]) begin
            pick        = 3'b010;
            m_row_index = e_meta_reg.row;
        end else begin
            pick        = 3'b100;
            m_row_index = IDX_OUT_W'(32'(h_lim) - 32'd1);
        end
        pend_after = e_pend_reg & ~pick;
    end

    assign m_valid     = e_valid_reg;
    assign m_col_index = e_meta_reg.col;
    assign m_new_value = e_value_reg;
    assign m_grid_done = e_meta_reg.last && (pend_after == 3'b000);
    assign e_done      = e_valid_reg && m_ready && (pend_after == 3'b000);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
            e_pend_reg  <= 3'b000;
        end else if (en4) begin
            e_valid_reg <= v4_reg;
            e_pend_reg  <= v4_reg ? {s4_meta_reg.bot, 1'b1, s4_meta_reg.top} : 3'b000;
        end else if (m_valid && m_ready) begin
            e_pend_reg  <= pend_after;
        end
        if (en4 && v4_reg) begin
            e_meta_reg  <= s4_meta_reg;
            e_value_reg <= res_val;
        end
    end

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------

    // delayed prev2 write never hits the entry being read
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && adv1 |-> s1_addr_reg != col_cnt_reg)
        else $error("prev2 write collides with read");

    // a held output always has a copy left to send
    assert property (@(posedge aclk) disable iff (!aresetn)
        e_valid_reg |-> e_pend_reg != 3'b000)
        else $error("output register valid with nothing pending");

    // end of grid is the bottom copy of the last row
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_grid_done |-> e_meta_reg.bot
            && m_row_index == IDX_OUT_W'(32'(h_lim) - 32'd1))
        else $error("grid_done on a result outside the last row");

    // the row 0 copy only comes from row 1
    assert property (@(posedge aclk) disable iff (!aresetn)
        e_valid_reg && e_pend_reg[0] |-> e_meta_reg.row == IDX_OUT_W'(1))
        else $error("top copy from a row other than row 1");

endmodule
